@@ rtl/frg_pkg.sv @@
`default_nettype none
package frg_pkg;
    localparam int WIDTH = 32;
    localparam int CW = $clog2(WIDTH + 2);

    typedef struct packed {
        logic signed [WIDTH-1:0] num_in;
        logic signed [WIDTH-1:0] den_in;
    } t_in;

    typedef struct packed {
        logic signed [WIDTH-1:0] num_out;
        logic [WIDTH-2:0]        den_out;
        logic                    zero_den_error;
    } t_out;

    typedef struct packed {
        logic [WIDTH-1:0] nm;
        logic [WIDTH-1:0] dm;
        logic             neg;
        logic             special;
        logic             zero_den;
    } t_job;
endpackage
`default_nettype wire

@@ rtl/frg_front.sv @@
`default_nettype none
module frg_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire frg_pkg::t_in  i_in,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output frg_pkg::t_job      o_job,
    output logic               o_job_valid,
    input  wire logic          i_job_ready
);
    import frg_pkg::*;

    localparam int DEPTH = 2;

    t_job r_q [DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job n_job;
    logic [WIDTH-1:0] nm, dm;
    logic push, pop;

    always_comb begin
        nm = i_in.num_in[WIDTH-1] ? WIDTH'(-i_in.num_in) : i_in.num_in;
        dm = i_in.den_in[WIDTH-1] ? WIDTH'(-i_in.den_in) : i_in.den_in;
        n_job.nm = nm;
        n_job.dm = dm;
        n_job.neg = i_in.num_in[WIDTH-1] ^ i_in.den_in[WIDTH-1];
        n_job.zero_den = (dm == '0);
        n_job.special = (dm == '0) || (nm == '0);
    end

    assign o_in_ready  = (r_cnt != 2'(DEPTH));
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign push = i_in_valid && o_in_ready;
    assign pop  = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_job;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/frg_back.sv @@
`default_nettype none
module frg_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire frg_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    output frg_pkg::t_out      o_out,
    output logic               o_out_valid,
    input  wire logic          i_out_ready
);
    import frg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MOD, S_DIVN, S_DIVD, S_DONE} t_state;

    t_state r_state;
    logic [WIDTH-1:0] r_a, r_b, r_nm, r_dm, r_rn, r_q, r_rem, r_div;
    logic [CW-1:0] r_cnt;
    logic r_neg;
    t_out r_out;
    logic r_out_valid;
    logic [WIDTH:0] trial;
    logic [WIDTH-1:0] rem_sh;
    logic [WIDTH-1:0] src;
    logic [$clog2(WIDTH)-1:0] bit_idx;
    logic [WIDTH-1:0] rn_sat, rd_sat;
    localparam logic [WIDTH-1:0] MAG_MAX = {1'b0, {(WIDTH-1){1'b1}}};

    assign o_job_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out = r_out;
    assign o_out_valid = r_out_valid;

    always_comb begin
        src = (r_state == S_MOD) ? r_a : ((r_state == S_DIVN) ? r_nm : r_dm);
        bit_idx = $clog2(WIDTH)'(r_cnt - CW'(1));
        rem_sh = {r_rem[WIDTH-2:0], src[bit_idx]};
        trial = {1'b0, rem_sh} - {1'b0, r_div};
        rn_sat = (r_rn > MAG_MAX) ? MAG_MAX : r_rn;
        rd_sat = (r_q > MAG_MAX) ? MAG_MAX : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid && o_job_ready) begin
                        r_nm <= i_job.nm;
                        r_dm <= i_job.dm;
                        r_neg <= i_job.neg;
                        if (i_job.special) begin
                            r_out.num_out <= '0;
                            r_out.den_out <= (WIDTH-1)'(1);
                            r_out.zero_den_error <= i_job.zero_den;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_a <= i_job.nm;
                            r_b <= i_job.dm;
                            r_div <= i_job.dm;
                            r_rem <= '0;
                            r_q <= '0;
                            r_cnt <= CW'(WIDTH);
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD, S_DIVN, S_DIVD: begin
                    if (!trial[WIDTH]) begin
                        r_rem <= trial[WIDTH-1:0];
                        r_q <= {r_q[WIDTH-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_q <= {r_q[WIDTH-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_cnt <= CW'(WIDTH);
                        r_rem <= '0;
                        r_q <= '0;
                        if (r_state == S_MOD) begin
                            if (trial[WIDTH] ? (rem_sh == '0) : (trial[WIDTH-1:0] == '0)) begin
                                r_div <= r_b;
                                r_state <= S_DIVN;
                            end else begin
                                r_a <= r_b;
                                r_b <= trial[WIDTH] ? rem_sh : trial[WIDTH-1:0];
                                r_div <= trial[WIDTH] ? rem_sh : trial[WIDTH-1:0];
                            end
                        end else if (r_state == S_DIVN) begin
                            r_rn <= {r_q[WIDTH-2:0], ~trial[WIDTH]};
                            r_state <= S_DIVD;
                        end else begin
                            r_q <= {r_q[WIDTH-2:0], ~trial[WIDTH]};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.num_out <= r_neg ? -rn_sat : rn_sat;
                        r_out.den_out <= rd_sat[WIDTH-2:0];
                        r_out.zero_den_error <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/fraction_reduce_gcd.sv @@
// Reduces a signed fraction to lowest terms with a positive denominator.
// Input beats carry num_in and den_in on a valid/ready channel; result
// beats carry num_out, den_out and zero_den_error on a second one.
// A front stage takes magnitudes and flags special cases, and a
// two-entry queue holds items for the back stage.
// The back stage runs Euclid's algorithm with a bit-serial divider
// for each remainder, then divides numerator and denominator by the
// GCD; it takes a new item only once the last one is finished. Zero
// numerators or denominators skip the divider.
// Results appear in input order. When the receiver stalls, the finished
// result is held, the back stage waits, and the queue fills before input
// ready drops. Synchronous reset empties the queue and the output.
`default_nettype none
module fraction_reduce_gcd (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire frg_pkg::t_in  i_in,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output frg_pkg::t_out      o_out,
    output logic               o_out_valid,
    input  wire logic          i_out_ready
);
    import frg_pkg::*;

    t_job job;
    logic job_valid, job_ready;

    frg_front u_front (
        .i_clk, .i_rst_n, .i_in, .i_in_valid, .o_in_ready,
        .o_job(job), .o_job_valid(job_valid), .i_job_ready(job_ready)
    );

    frg_back u_back (
        .i_clk, .i_rst_n, .i_job(job), .i_job_valid(job_valid),
        .o_job_ready(job_ready), .o_out, .o_out_valid, .i_out_ready
    );
endmodule
`default_nettype wire

@@ rtl/frg_checker.sv @@
`default_nettype none
module frg_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire frg_pkg::t_out o_out
);
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.den_out != '0) else $error("zero denominator out");
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.zero_den_error |-> o_out.num_out == '0 && o_out.den_out == 1)
        else $error("bad error result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out)) else $error("output dropped");
endmodule
bind fraction_reduce_gcd frg_checker u_chk (.*);
`default_nettype wire

@@ bench/tb_fraction_reduce_gcd.sv @@
`default_nettype none
module tb_fraction_reduce_gcd;
    import frg_pkg::*;

    logic i_clk;
    logic i_rst_n;
    t_in  i_in;
    logic i_in_valid;
    logic o_in_ready;
    t_out o_out;
    logic o_out_valid;
    logic i_out_ready;

    fraction_reduce_gcd dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .o_out(o_out), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready)
    );

    t_out expected_fracs[$];
    int   mismatch_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [WIDTH-1:0] euclid_gcd(logic [WIDTH-1:0] a,
                                                    logic [WIDTH-1:0] b);
        logic [WIDTH-1:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic t_out reduce_frac(t_in f);
        t_out             res;
        logic [WIDTH-1:0] nm;
        logic [WIDTH-1:0] dm;
        logic [WIDTH-1:0] g;
        logic [WIDTH-1:0] rn;
        logic [WIDTH-1:0] rd;
        logic [WIDTH-1:0] mag_max;
        mag_max = {1'b0, {(WIDTH-1){1'b1}}};
        nm = f.num_in[WIDTH-1] ? -f.num_in : f.num_in;
        dm = f.den_in[WIDTH-1] ? -f.den_in : f.den_in;
        res.num_out = '0;
        res.den_out = (WIDTH-1)'(1);
        res.zero_den_error = 1'b0;
        if (dm == 0) begin
            res.zero_den_error = 1'b1;
        end else if (nm != 0) begin
            g = euclid_gcd(nm, dm);
            rn = nm / g;
            rd = dm / g;
            if (rn > mag_max) rn = mag_max;
            if (rd > mag_max) rd = mag_max;
            res.num_out = (f.num_in[WIDTH-1] != f.den_in[WIDTH-1]) ? -rn : rn;
            res.den_out = rd[WIDTH-2:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [WIDTH-1:0] got,
                                   logic [WIDTH-1:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_frac(logic signed [WIDTH-1:0] n, logic signed [WIDTH-1:0] d);
        t_in f;
        f.num_in = n;
        f.den_in = d;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in <= f;
        i_in_valid <= 1'b1;
        expected_fracs.push_back(reduce_frac(f));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // The receiver decides ready once per cycle; a nonzero hold_cycles forces a long stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_fracs.size() == 0) begin
                report_mismatch("unexpected beat", o_out.num_out, 0);
            end else begin
                want = expected_fracs.pop_front();
                if (o_out.num_out !== want.num_out)
                    report_mismatch("num_out", o_out.num_out, want.num_out);
                if (o_out.den_out !== want.den_out)
                    report_mismatch("den_out", WIDTH'(o_out.den_out), WIDTH'(want.den_out));
                if (o_out.zero_den_error !== want.zero_den_error)
                    report_mismatch("zero_den_error", WIDTH'(o_out.zero_den_error),
                                    WIDTH'(want.zero_den_error));
            end
        end
    end

    function automatic logic signed [WIDTH-1:0] rand_val();
        logic signed [WIDTH-1:0] v;
        case ($urandom_range(4))
            0: v = $urandom_range(20);
            1: v = -$signed($urandom_range(20));
            2: v = $urandom_range(5000) * 7;
            default: v = $urandom;
        endcase
        if (v == {1'b1, {(WIDTH-1){1'b0}}}) v = v + 1;
        return v;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_fracs.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic signed [WIDTH-1:0] maxp;
        maxp = {1'b0, {(WIDTH-1){1'b1}}};
        send_frac(0, 0);
        send_frac(5, 0);
        send_frac(-maxp, 0);
        send_frac(0, 7);
        send_frac(0, -maxp);
        send_frac(6, 4);
        send_frac(-6, 4);
        send_frac(6, -4);
        send_frac(-6, -4);
        send_frac(maxp, maxp);
        send_frac(-maxp, maxp);
        send_frac(maxp, 1);
        send_frac(1, -maxp);
        send_frac(maxp, 2);
        send_frac(1836311903, 1134903170);
        send_frac(-1, -1);
        send_frac(12, 144);
        wait_drained();
    endtask

    task automatic test_random(int count, int sp, int rp);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        repeat (count) begin
            if ($urandom_range(19) == 0) send_frac(rand_val(), 0);
            else if ($urandom_range(9) == 0) send_frac(rand_val() * 6, rand_val() * 6);
            else send_frac(rand_val(), rand_val());
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 2000;
        repeat (8) send_frac(rand_val(), rand_val());
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in = '0;
        i_in_valid = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(280, 9, 48);
        test_backpressure();
        test_random(280, 48, 9);
        test_random(280, 0, 0);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && expected_fracs.size() == 0) begin
            $display("[fraction_reduce_gcd] OK");
        end else begin
            $display("[fraction_reduce_gcd] ERROR");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("[fraction_reduce_gcd] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

@@ fraction_reduce_gcd.f @@
rtl/frg_pkg.sv
rtl/frg_front.sv
rtl/frg_back.sv
rtl/fraction_reduce_gcd.sv
rtl/frg_checker.sv
bench/tb_fraction_reduce_gcd.sv
